// File: rtl/core/csas_pkg.sv
// shared types and constants of the count-smaller-after-self block
package csas_pkg;

  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned CountW      = 6;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     is_last;
  } csas_in_t;

  typedef struct packed {
    logic [CountW-1:0] smaller_count;
    logic              is_last_res;
    logic              overflow;
  } csas_out_t;

  // sequencer to comparator controls
  typedef struct packed {
    logic pivot_ld;  // latch read data as pivot, clear count
    logic acc;       // read data is a later value to compare
  } csas_cmp_ctrl_t;

endpackage

// File: rtl/core/csas_ram.sv
// generic single-write, single-read ram with registered read data
module csas_ram #(
  parameter int unsigned WIDTH = csas_pkg::ValueW,
  parameter int unsigned DEPTH = csas_pkg::MaxItemsDef
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/csas_cmp.sv
// shared signed comparator with pivot and smaller-count accumulator
module csas_cmp (
  input  logic                          clk,
  input  csas_pkg::csas_cmp_ctrl_t      ctrl,
  input  logic [csas_pkg::ValueW-1:0]   rd_data,
  output logic [csas_pkg::CountW-1:0]   count
);

  logic [csas_pkg::ValueW-1:0] pivot_r;
  logic [csas_pkg::CountW-1:0] count_r;
  logic                        lt;

  // strictly smaller, equal values do not count
  assign lt = $signed(rd_data) < $signed(pivot_r);

  always_ff @(posedge clk) begin
    if (ctrl.pivot_ld) begin
      pivot_r <= rd_data;
      count_r <= '0;
    end else if (ctrl.acc && lt) begin
      count_r <= count_r + csas_pkg::CountW'(1);
    end
  end

  assign count = count_r;

endmodule

// File: rtl/core/csas_seq.sv
// sequencer: load phase, per-element scan, result register
module csas_seq #(
  parameter int unsigned MAX_ITEMS = csas_pkg::MaxItemsDef
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  csas_pkg::csas_in_t               in_data,
  output logic                             in_stall,
  output logic                             out_valid,
  input  logic                             out_stall,
  output csas_pkg::csas_out_t              out_data,
  output logic                             wr_en,
  output logic [$clog2(MAX_ITEMS)-1:0]     wr_addr,
  output logic [$clog2(MAX_ITEMS)-1:0]     rd_addr,
  output csas_pkg::csas_cmp_ctrl_t         cmp_ctrl,
  input  logic [csas_pkg::CountW-1:0]      cmp_count
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PIVOT,
    S_PIVLD,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       item_count_r, item_count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [AW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic                cmp_v_r, cmp_v_nxt;
  logic                out_valid_r, out_valid_nxt;
  csas_pkg::csas_out_t out_data_r, out_data_nxt;
  logic                i_last;
  logic                more;

  assign i_last = (CW'(i_r) + CW'(1)) == item_count_r;
  assign more   = j_r < item_count_r;

  always_comb begin
    state_nxt      = state_r;
    item_count_nxt = item_count_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    cmp_v_nxt      = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    cmp_ctrl       = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (item_count_r < CW'(MAX_ITEMS)) begin
            wr_en          = 1'b1;
            item_count_nxt = item_count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            i_nxt     = '0;
            state_nxt = S_PIVOT;
          end
        end
      end
      S_PIVOT: begin
        j_nxt     = CW'(i_r) + CW'(1);
        state_nxt = S_PIVLD;
      end
      S_PIVLD, S_SCAN: begin
        cmp_ctrl.pivot_ld = (state_r == S_PIVLD);
        cmp_ctrl.acc      = (state_r == S_SCAN) && cmp_v_r;
        if (more) begin
          j_nxt     = j_r + CW'(1);
          cmp_v_nxt = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.smaller_count = cmp_count;
          out_data_nxt.is_last_res   = i_last;
          out_data_nxt.overflow      = ovf_r;
          if (i_last) begin
            item_count_nxt = '0;
            ovf_nxt        = 1'b0;
            state_nxt      = S_LOAD;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_PIVOT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      item_count_r <= '0;
      ovf_r        <= 1'b0;
      cmp_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      ovf_r        <= ovf_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_addr   = item_count_r[AW-1:0];
  assign rd_addr   = (state_r == S_PIVOT) ? i_r : j_r[AW-1:0];

endmodule

// File: rtl/core/count_smaller_after_self_core.sv
// top level of the count-smaller-after-self block
//
//   channel | direction | payload      | handshake
//   --------+-----------+--------------+-------------------------------
//   in_     | input     | csas_in_t    | in_valid / in_stall (driven here)
//   out_    | output    | csas_out_t   | out_valid (driven here) / out_stall
//
// load: one item per cycle, stored at the next free ram address while room is left
// report: per element i, a pivot read, a pivot latch, one ram read and
//   compare per later element, then the result load; elements go one at a
//   time through the single ram read port and comparator
// in_stall is high from the item marked last until the final result is loaded
// out_stall only holds the result register; a held result delays the next one
// reset (rst_n low, synchronous) empties the set; ram contents need no clear
module count_smaller_after_self_core #(
  parameter int unsigned MAX_ITEMS = csas_pkg::MaxItemsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  csas_pkg::csas_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output csas_pkg::csas_out_t out_data
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);

  // value store write side, fed straight from the accepted item
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  // read side, shared by pivot fetch and the scan of later values
  logic [AW-1:0]                 rd_addr;
  logic [csas_pkg::ValueW-1:0]   rd_data;
  // comparator control and its running count
  csas_pkg::csas_cmp_ctrl_t      cmp_ctrl;
  logic [csas_pkg::CountW-1:0]   cmp_count;

  csas_seq #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .cmp_ctrl  (cmp_ctrl),
    .cmp_count (cmp_count)
  );

  // value store, one entry per element of the current set
  csas_ram #(
    .WIDTH (csas_pkg::ValueW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // the one comparator, reused for every pair
  csas_cmp u_cmp (
    .clk     (clk),
    .ctrl    (cmp_ctrl),
    .rd_data (rd_data),
    .count   (cmp_count)
  );

endmodule

// File: rtl/core/csas_chk.sv
// port-level checker for the count-smaller-after-self block, with its bind
module csas_chk #(
  parameter int unsigned MAX_ITEMS = csas_pkg::MaxItemsDef
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input csas_pkg::csas_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input csas_pkg::csas_out_t out_data
);

  // a non-final item keeps the block in its load phase
  a_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.is_last |=> !in_stall)
    else $error("input closed after a non-final item");

  // the final item starts the report phase
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.is_last |=> in_stall)
    else $error("input still open after the final item");

  // a count stays below the capacity MAX_ITEMS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.smaller_count) < MAX_ITEMS))
    else $error("smaller count out of range");

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind count_smaller_after_self_core csas_chk #(
  .MAX_ITEMS (MAX_ITEMS)
) u_csas_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/count_smaller_after_self_tb.sv
// self-checking testbench for the count-smaller-after-self block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csas_pkg::*;

  localparam int unsigned Capacity = MaxItemsDef;

  typedef logic signed [ValueW-1:0] value_t;
  typedef value_t value_list_t[$];

  localparam value_t ValueMin = 32'sh8000_0000;
  localparam value_t ValueMax = 32'sh7fff_ffff;

  typedef enum int unsigned {SpreadFull, SpreadNarrow, SpreadEdge, SpreadMixed} value_spread_t;
  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallBeat} stall_mode_t;

  // keeps its own copy of the loaded set and the counts still to be reported
  class smaller_count_board;
    value_t      held [Capacity];
    int unsigned held_n;
    bit          dropped_any;
    csas_out_t   awaited[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned sets_closed;
    int unsigned overflow_sets;

    function new();
      held_n        = 0;
      dropped_any   = 1'b0;
      mismatches    = 0;
      results_seen  = 0;
      sets_closed   = 0;
      overflow_sets = 0;
    endfunction

    function void note_value(csas_in_t it);
      int unsigned cnt;
      csas_out_t   res;
      if (held_n < Capacity) begin
        held[held_n] = it.value;
        held_n++;
      end else begin
        dropped_any = 1'b1;
      end
      if (it.is_last) begin
        for (int unsigned i = 0; i < held_n; i++) begin
          cnt = 0;
          for (int unsigned j = i + 1; j < held_n; j++) begin
            if (held[j] < held[i]) cnt++;
          end
          res.smaller_count = cnt[CountW-1:0];
          res.is_last_res   = (i + 1 == held_n);
          res.overflow      = dropped_any;
          awaited = {awaited, res};
        end
        sets_closed++;
        if (dropped_any) overflow_sets++;
        held_n      = 0;
        dropped_any = 1'b0;
      end
    endfunction

    function void check_result(csas_out_t got);
      csas_out_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual count %0d last %0b overflow %0b",
                 $time, got.smaller_count, got.is_last_res, got.overflow);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.smaller_count !== want.smaller_count) begin
        $display("%0t: smaller_count mismatch: expected %0d actual %0d",
                 $time, want.smaller_count, got.smaller_count);
        mismatches++;
      end
      if (got.is_last_res !== want.is_last_res) begin
        $display("%0t: is_last_res mismatch: expected %0b actual %0b",
                 $time, want.is_last_res, got.is_last_res);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow mismatch: expected %0b actual %0b",
                 $time, want.overflow, got.overflow);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  csas_in_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  csas_out_t out_data;

  smaller_count_board board = new();

  bit          hold_req   = 1'b0;
  bit          gappy      = 1'b0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  count_smaller_after_self_core #(
    .MAX_ITEMS(Capacity)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // result side: check accepted results, stall on a mode that changes now and then
  initial begin
    int unsigned hold_left;
    int unsigned phase_left;
    int unsigned tick;
    stall_mode_t mode;
    hold_left  = 0;
    phase_left = 0;
    tick       = 0;
    mode       = StallNone;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      if (hold_req) begin
        hold_left = 2500;
        hold_req  = 1'b0;
      end
      if (phase_left == 0) begin
        mode       = stall_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      tick++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          StallNone:  out_stall <= 1'b0;
          StallLight: out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
          default:    out_stall <= tick[1];
        endcase
      end
    end
  end

  // offer one item and hold it until taken; gaps come between bursts when gappy is set
  task automatic offer_item(input value_t v, input bit last);
    csas_in_t it;
    it.value   = v;
    it.is_last = last;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_value(it);
    items_sent++;
    if (gappy) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_set(input value_list_t vals);
    foreach (vals[k]) offer_item(vals[k], k == vals.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_value(value_spread_t spread);
    case (spread)
      SpreadFull:   return value_t'($urandom);
      SpreadNarrow: return value_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0:       return ValueMin;
          1:       return ValueMax;
          2:       return value_t'(0);
          default: return value_t'(-1);
        endcase
      end
    endcase
  endfunction

  initial begin
    value_list_t   vals;
    int unsigned   size;
    value_spread_t spread;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single element, extremes with a repeat, all equal, strictly falling
    vals = '{ValueMin};
    send_set(vals);
    vals = '{ValueMax, ValueMin, value_t'(0), value_t'(-1), ValueMax};
    send_set(vals);
    vals = '{value_t'(5), value_t'(5), value_t'(5)};
    send_set(vals);
    vals = '{value_t'(3), value_t'(2), value_t'(1), value_t'(0)};
    send_set(vals);
    wait_drained();

    // receiver holds off while sets keep coming, so the input side backs up
    hold_req = 1'b1;
    repeat (3) begin
      vals.delete();
      repeat (5) vals = {vals, pick_value(SpreadNarrow)};
      send_set(vals);
    end
    wait_drained();

    // full store: falling run gives the largest count, then a set past capacity
    gappy = 1'b1;
    vals.delete();
    for (int k = Capacity - 1; k >= 0; k--) vals = {vals, value_t'(k)};
    send_set(vals);
    vals.delete();
    repeat (Capacity + 2) vals = {vals, pick_value(SpreadFull)};
    send_set(vals);

    while (items_sent < 425) begin
      gappy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 19) == 0) size = $urandom_range(Capacity - 4, Capacity + 6);
      else size = $urandom_range(1, 12);
      spread = value_spread_t'($urandom_range(0, 3));
      vals.delete();
      repeat (size) begin
        if (spread == SpreadMixed) begin
          vals = {vals, pick_value(value_spread_t'($urandom_range(0, 2)))};
        end else begin
          vals = {vals, pick_value(spread)};
        end
      end
      send_set(vals);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);

    $display("run covered %0d items in %0d sets, %0d of them past capacity",
             items_sent, board.sets_closed, board.overflow_sets);
    $display("%0d results checked, %0d mismatches", board.results_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
